/* src/quadrature_encoder_decoder_assert.svh */
// assertion macros for the quadrature encoder decoder
// used by the top level, no other dependencies
`ifndef QUADRATURE_ENCODER_DECODER_ASSERT_SVH
`define QUADRATURE_ENCODER_DECODER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define QED_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define QED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/qed_pkg.sv */
// shared types and codes for the quadrature encoder decoder
// no dependencies
`timescale 1ns / 1ps

package qed_pkg;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_STEPS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_LIMIT = 2'd2;

    // trigger modes
    localparam logic [1:0] TRIG_POLLED = 2'd0;
    localparam logic [1:0] TRIG_EDGE_A = 2'd1;
    localparam logic [1:0] TRIG_EDGE_B = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    // reset values
    localparam logic [2:0]  SUB_STEPS_RESET = 3'd4;
    localparam logic [31:0] HOLDOFF_CAP     = 32'hFFFF_FFFE;
    localparam logic [31:0] HOLDOFF_EXPIRED = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  trigger_mode;
        logic [2:0]  sub_steps;
        logic [31:0] holdoff_limit;
    } cfg_t;

endpackage

/* src/qed_cfg_regs.sv */
// configuration registers of the quadrature encoder decoder
// depends on qed_pkg
`timescale 1ns / 1ps

module qed_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [qed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qed_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output qed_pkg::cfg_t                   cfg
);
    import qed_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_TRIGGER_MODE:  cfg_next.trigger_mode  = cfg_wdata[1:0];
                REG_SUB_STEPS:     cfg_next.sub_steps     = cfg_wdata[2:0];
                REG_HOLDOFF_LIMIT: cfg_next.holdoff_limit = cfg_wdata[31:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.trigger_mode  <= TRIG_POLLED;
            cfg_reg.sub_steps     <= SUB_STEPS_RESET;
            cfg_reg.holdoff_limit <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/qed_step_core.sv */
// decoder state and step logic: gray decode, hold-off, step count
// depends on qed_pkg
`timescale 1ns / 1ps

module qed_step_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          advance,
    input  logic          pin_a,
    input  logic          pin_b,
    input  qed_pkg::cfg_t cfg,
    output logic [1:0]    dir,
    output logic [31:0]   step_total
);
    import qed_pkg::*;

    logic [1:0]  last_pos_reg,  last_pos_next;
    logic        known_reg,     known_next;
    logic [31:0] holdoff_reg,   holdoff_next;
    logic [31:0] total_reg,     total_next;

    logic [31:0]       limit;
    logic [1:0]        pos;
    logic signed [2:0] delta;
    logic signed [3:0] delta_x;
    logic signed [3:0] t;
    logic signed [3:0] neg_t;
    logic              match;

    assign limit   = (cfg.holdoff_limit == HOLDOFF_EXPIRED) ? HOLDOFF_CAP : cfg.holdoff_limit;
    assign pos     = {pin_a, pin_a ^ pin_b};
    assign delta   = $signed({1'b0, last_pos_reg}) - $signed({1'b0, pos});
    assign delta_x = {delta[2], delta};
    assign t       = $signed({1'b0, cfg.sub_steps}) - 4'sd1;
    assign neg_t   = -t;
    assign match   = (delta_x == t) || (delta_x == neg_t);

    always_comb begin
        last_pos_next = last_pos_reg;
        known_next    = known_reg;
        holdoff_next  = holdoff_reg;
        dir           = DIR_NONE;
        case (cfg.trigger_mode)
            TRIG_POLLED: begin
                if (holdoff_reg < limit) begin
                    holdoff_next = holdoff_reg + 32'd1;
                end else if (!known_reg) begin
                    last_pos_next = pos;
                    known_next    = 1'b1;
                end else begin
                    last_pos_next = pos;
                    if (delta != 3'sd0) begin
                        holdoff_next = '0;
                        if (match) begin
                            dir = delta[1] ? DIR_LEFT : DIR_RIGHT;
                        end
                    end
                end
            end
            TRIG_EDGE_A: dir = (pin_a == pin_b) ? DIR_LEFT : DIR_RIGHT;
            TRIG_EDGE_B: dir = (pin_b != pin_a) ? DIR_LEFT : DIR_RIGHT;
            default:     dir = DIR_NONE;
        endcase

        case (dir)
            DIR_LEFT:  total_next = total_reg - 32'd1;
            DIR_RIGHT: total_next = total_reg + 32'd1;
            default:   total_next = total_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_pos_reg <= '0;
            known_reg    <= 1'b0;
            holdoff_reg  <= HOLDOFF_EXPIRED;
            total_reg    <= '0;
        end else if (advance) begin
            last_pos_reg <= last_pos_next;
            known_reg    <= known_next;
            holdoff_reg  <= holdoff_next;
            total_reg    <= total_next;
        end
    end

    assign step_total = total_next;

endmodule

/* src/quadrature_encoder_decoder.sv */
// quadrature encoder decoder, top level: input register, step core, result register
// depends on qed_pkg, qed_cfg_regs, qed_step_core and the assertion macro header
// flow: input register, then result register once that stage is empty or being drained
// throughput: one sample per cycle unless m_ready stalls, combinational step core between the registers
// reset: synchronous active-low aresetn empties both stages and restores register defaults
`timescale 1ns / 1ps

`include "quadrature_encoder_decoder_assert.svh"

module quadrature_encoder_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port, the user must write it only while the block is idle; not enforced by the block
    input  logic                            cfg_we,
    input  logic [qed_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qed_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // pin sample channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_pin_a,
    input  logic                            s_pin_b,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_direction,
    output logic signed [31:0]              m_step_count
);
    import qed_pkg::*;

    cfg_t cfg;

    // input stage holds one pin sample
    logic        in_valid_reg, in_valid_next;
    logic        pin_a_reg;
    logic        pin_b_reg;

    // result stage
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  dir_reg;
    logic [31:0] count_reg;

    logic        advance;
    logic        s_xfer;
    logic [1:0]  core_dir;
    logic [31:0] core_total;

    // the sample moves into the result stage when that stage is empty or is being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // the input stage takes a new sample whenever it is empty or moving on this cycle
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    qed_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // decoder state advances only when a sample is handed to the result stage
    qed_step_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .pin_a      (pin_a_reg),
        .pin_b      (pin_b_reg),
        .cfg        (cfg),
        .dir        (core_dir),
        .step_total (core_total)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pin_a_reg <= s_pin_a;
            pin_b_reg <= s_pin_b;
        end
        if (advance) begin
            dir_reg   <= core_dir;
            count_reg <= core_total;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_direction  = dir_reg;
    assign m_step_count = $signed(count_reg);

    // a stalled result must block the input stage from moving on
    `QED_ASSERT_SAME(a_no_overrun, aclk, aresetn, m_valid && !m_ready, !advance,
        "result overwritten while stalled")
    // a sample handed on always shows up as a result next cycle
    `QED_ASSERT_NEXT(a_result_follows, aclk, aresetn, advance, m_valid,
        "sample handed on but no result offered")
    // a held sample is not dropped
    `QED_ASSERT_NEXT(a_sample_kept, aclk, aresetn, in_valid_reg && !advance, in_valid_reg,
        "held sample lost")
    // an empty input stage always takes a transfer
    `QED_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_ready,
        "input stage empty but not ready")

endmodule
